// ----- rtl/ipv6_pkg.sv -----
`timescale 1ns / 1ps
package ipv6_pkg;
  localparam int PoolEntries  = 1024;
  localparam int BucketCount  = 4096;
  localparam int EntryW       = $clog2(PoolEntries);
  localparam int LinkW        = $clog2(PoolEntries + 1);
  localparam int BucketW      = $clog2(BucketCount);

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH0, ST_HASH1, ST_HASH2, ST_HASH3, ST_HASH4,
    ST_HEAD, ST_HEAD_WAIT, ST_WALK, ST_WALK_WAIT, ST_UPDATE, ST_OUT
  } state_t;

  // bucket index: 64-bit value folded by xor into BucketW bits
  function automatic logic [BucketW-1:0] fold_bits(input logic [63:0] v);
    logic [BucketW-1:0] acc;
    acc = '0;
    for (int i = 0; i < 64; i += BucketW) acc ^= BucketW'(v >> i);
    return acc;
  endfunction
endpackage

// ----- rtl/ipv6_hash.sv -----
`timescale 1ns / 1ps
module ipv6_hash (
  input  logic                    clk,
  input  logic                    start,
  input  logic [63:0]             addr_hi,
  input  logic [63:0]             addr_lo,
  output logic [ipv6_pkg::BucketW-1:0] bucket
);
  import ipv6_pkg::*;
  // one 32x32 multiply per cycle mixes the folded address
  logic [31:0] fold_r;
  logic [63:0] prod_r;
  always_ff @(posedge clk) begin
    if (start) fold_r <= addr_hi[63:32] ^ addr_hi[31:0] ^ {addr_lo[31:0]} ^ addr_lo[63:32]
                         ^ {addr_lo[15:0], addr_hi[47:32]};
    prod_r <= 64'(fold_r) * 64'h9E3779B9;
  end
  assign bucket = fold_bits(prod_r ^ (prod_r >> 29));
endmodule

// ----- rtl/ipv6_address_flag_table.sv -----
`timescale 1ns / 1ps
// IPv6 address flag table: exact-match store of up to 1024 IPv6 addresses with
// 8 flag bits each, chained in 4096 hash buckets.
// Input channel in_valid/in_ready carries in_func (lookup, set, clear, code 3
// acts as lookup), the address halves and in_flag_mask. Output channel
// out_valid/out_ready returns out_hit, out_flags and out_pool_full, one
// result per request, in order.
// Each request passes the hash states ST_HASH0 to ST_HASH4, a head read
// (ST_HEAD, ST_HEAD_WAIT), one entry memory read and compare (ST_WALK,
// ST_WALK_WAIT) per chain entry until a match or the chain end, and one
// update state (ST_UPDATE) before out_valid. One request is in work at a
// time; in_ready is low from acceptance until the cycle after the result
// is taken.
// After reset a clearing pass sweeps the bucket head memory, one bucket per
// cycle, through all 4096 buckets before the first request is accepted.
// A stalled receiver holds the result; the block waits on out_ready.
module ipv6_address_flag_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [7:0]  in_flag_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [7:0]  out_flags,
  output logic        out_pool_full
);
  import ipv6_pkg::*;

  state_t state_r, state_nxt;
  logic [BucketW-1:0] clr_r;
  logic [1:0]  func_r;
  logic [63:0] hi_r, lo_r;
  logic [7:0]  mask_r;
  logic [BucketW-1:0] bucket_r;
  logic [LinkW-1:0]   link_r;
  logic [LinkW-1:0]   used_r;
  logic [LinkW-1:0]   steps_r;
  logic        hit_r, full_r;
  logic [7:0]  flags_r;
  logic        is_empty_r;
  logic [EntryW-1:0] tail_rd_r;

  logic [LinkW-1:0]  head_mem [BucketCount];
  logic [EntryW-1:0] tail_mem [BucketCount];
  logic [LinkW-1:0]  next_mem [PoolEntries];
  logic [63:0]       khi_mem  [PoolEntries];
  logic [63:0]       klo_mem  [PoolEntries];
  logic [7:0]        flg_mem  [PoolEntries];

  logic [LinkW-1:0]  head_q;
  logic [LinkW-1:0]  next_q;
  logic [63:0]       khi_q, klo_q;
  logic [7:0]        flg_q;
  logic [BucketW-1:0] hash_bucket;

  // old tail link is written in the cycle after allocation
  logic              link_pend_r;
  logic [EntryW-1:0] link_e_r;
  logic [LinkW-1:0]  link_v_r;

  ipv6_hash u_hash (
    .clk(clk), .start(in_valid && in_ready),
    .addr_hi(in_addr_hi), .addr_lo(in_addr_lo), .bucket(hash_bucket)
  );

  logic [EntryW-1:0] cur_e;
  logic [EntryW-1:0] new_e;
  logic              key_eq;
  logic [7:0]        upd_flags;
  assign cur_e  = EntryW'(link_r - LinkW'(1));
  assign new_e  = EntryW'(used_r);
  assign key_eq = (khi_q == hi_r) && (klo_q == lo_r);
  always_comb begin
    case (func_r)
      FUNC_SET:   upd_flags = flg_q | mask_r;
      FUNC_CLEAR: upd_flags = flg_q & ~mask_r;
      default:    upd_flags = flg_q;
    endcase
  end

  // memory ports
  logic head_we, tail_we, new_we, flg_we;
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) head_mem[clr_r] <= '0;
    else if (head_we) head_mem[bucket_r] <= LinkW'(new_e) + LinkW'(1);
    head_q    <= head_mem[bucket_r];
    if (tail_we) tail_mem[bucket_r] <= new_e;
    tail_rd_r <= tail_mem[bucket_r];
  end
  always_ff @(posedge clk) begin
    if (new_we) begin
      khi_mem[new_e] <= hi_r;
      klo_mem[new_e] <= lo_r;
      next_mem[new_e] <= '0;
    end else if (link_pend_r) begin
      next_mem[link_e_r] <= link_v_r;
    end
    if (flg_we) flg_mem[new_we ? new_e : cur_e] <= new_we ? mask_r : upd_flags;
    khi_q  <= khi_mem[cur_e];
    klo_q  <= klo_mem[cur_e];
    next_q <= next_mem[cur_e];
    flg_q  <= flg_mem[cur_e];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + BucketW'(1);
      if (new_we) used_r <= used_r + LinkW'(1);
    end
  end

  logic walk_more;
  assign walk_more = (link_r != '0) && (link_r <= LinkW'(PoolEntries))
                     && (steps_r < LinkW'(PoolEntries));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func; hi_r <= in_addr_hi; lo_r <= in_addr_lo; mask_r <= in_flag_mask;
      hit_r <= 1'b0; full_r <= 1'b0; flags_r <= '0;
    end
    if (state_r == ST_HASH4) bucket_r <= hash_bucket;
    if (state_r == ST_HEAD_WAIT) begin
      link_r <= head_q; steps_r <= '0; is_empty_r <= (head_q == '0);
    end
    if (state_r == ST_WALK_WAIT) begin
      if (key_eq) begin
        hit_r <= 1'b1; flags_r <= upd_flags;
      end else begin
        link_r <= next_q; steps_r <= steps_r + LinkW'(1);
      end
    end
    if (state_r == ST_UPDATE && func_r == FUNC_SET && !hit_r) begin
      if (used_r >= LinkW'(PoolEntries)) full_r <= 1'b1;
      else flags_r <= mask_r;
    end
  end

  logic do_alloc;
  assign do_alloc = (state_r == ST_UPDATE) && (func_r == FUNC_SET) && !hit_r
                    && (used_r < LinkW'(PoolEntries));

  always_comb begin
    state_nxt    = state_r;
    head_we      = 1'b0;
    tail_we      = 1'b0;
    new_we       = 1'b0;
    flg_we       = 1'b0;
    case (state_r)
      ST_CLEAR:     if (clr_r == BucketW'(BucketCount - 1)) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_valid) state_nxt = ST_HASH0;
      ST_HASH0:     state_nxt = ST_HASH1;
      ST_HASH1:     state_nxt = ST_HASH2;
      ST_HASH2:     state_nxt = ST_HASH3;
      ST_HASH3:     state_nxt = ST_HASH4;
      ST_HASH4:     state_nxt = ST_HEAD;
      ST_HEAD:      state_nxt = ST_HEAD_WAIT;
      ST_HEAD_WAIT: state_nxt = ST_WALK;
      ST_WALK:      state_nxt = walk_more ? ST_WALK_WAIT : ST_UPDATE;
      ST_WALK_WAIT: begin
        // write back updated flags of a match
        if (key_eq) begin
          flg_we = 1'b1;
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_UPDATE: begin
        if (do_alloc) begin
          new_we = 1'b1;
          flg_we = 1'b1;
          tail_we = 1'b1;
          head_we = is_empty_r;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT:       if (out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) link_pend_r <= 1'b0;
    else link_pend_r <= do_alloc && !is_empty_r;
    link_e_r <= tail_rd_r;
    link_v_r <= LinkW'(new_e) + LinkW'(1);
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_hit       = hit_r;
  assign out_flags     = flags_r;
  assign out_pool_full = full_r;

  ap_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  ap_full_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_pool_full)) else $error("hit and full");
  ap_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= LinkW'(PoolEntries)) else $error("pool overrun");
  ap_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pool_full |-> out_flags == '0) else $error("flags on full");
endmodule
